// ===== hw/rtl/eisr_pkg.sv =====
package eisr_pkg;

   localparam int unsigned LETTER_W = 8;
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned STRIP_W  = 2;
   localparam int unsigned SUFFIX_W = 4;
   localparam int unsigned COUNT_W  = 3;
   localparam int unsigned TAIL_DEPTH = 4;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam count_type COUNT_MAX = count_type'(5);

   typedef enum logic [ACTION_W-1:0] {
      ACT_PLURAL      = 3'd0,
      ACT_PAST        = 3'd1,
      ACT_THIRD       = 3'd2,
      ACT_GERUND      = 3'd3,
      ACT_COMPARATIVE = 3'd4,
      ACT_SUPERLATIVE = 3'd5
   } action_type;

   typedef enum logic [SUFFIX_W-1:0] {
      SFX_S    = 4'd0,
      SFX_ES   = 4'd1,
      SFX_IES  = 4'd2,
      SFX_ED   = 4'd3,
      SFX_D    = 4'd4,
      SFX_IED  = 4'd5,
      SFX_ING  = 4'd6,
      SFX_YING = 4'd7,
      SFX_ER   = 4'd8,
      SFX_R    = 4'd9,
      SFX_IER  = 4'd10,
      SFX_EST  = 4'd11,
      SFX_ST   = 4'd12,
      SFX_IEST = 4'd13
   } suffix_type;

endpackage

// ===== hw/rtl/eisr_if.sv =====
interface eisr_req_if;
   logic                                valid;
   logic                                ready;
   logic [eisr_pkg::LETTER_W-1:0]       letter;
   logic [eisr_pkg::ACTION_W-1:0]       action;
   logic                                last;

   modport source (output valid, letter, action, last, input ready);
   modport sink   (input valid, letter, action, last, output ready);
endinterface

interface eisr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [eisr_pkg::STRIP_W-1:0]        strip_count;
   logic                                double_final;
   logic [eisr_pkg::LETTER_W-1:0]       doubled_letter;
   logic [eisr_pkg::SUFFIX_W-1:0]       suffix_code;
   logic                                no_form;

   modport source (output valid, strip_count, double_final, doubled_letter, suffix_code,
                   no_form, input ready);
   modport sink   (input valid, strip_count, double_final, doubled_letter, suffix_code,
                   no_form, output ready);
endinterface

// ===== hw/rtl/english_inflection_suffix_rules.sv =====
// Regular English inflection: edit descriptor per lemma.
//
// req_chan takes one lowercase lemma letter per transaction; last marks the
// final letter and action (read on that letter only) picks the form wanted.
// rsp_chan gives one edit descriptor per lemma: letters to strip, whether to
// double the final letter, the suffix code and the more/most flag. Lemmas
// ending with an unused action code produce no response.
//
// Throughput: one letter per cycle while req_chan.ready is high. The final
// letter is captured in the input stage register, then rule logic writes the
// descriptor into the output register that drives rsp_chan. Letters without
// last only update the tail shift register and length counter, no response.
//
// When rsp_chan stalls, the output register holds its descriptor and the
// input stage can still hold one more; req_chan.ready drops only when both
// are full. Reset (synchronous) clears the tail letters, the length count
// and both stage valid flags.
module english_inflection_suffix_rules (
   input logic          clock,
   input logic          reset,
   eisr_req_if.sink     req_chan,
   eisr_rsp_if.source   rsp_chan
);

   eisr_pkg::letter_type tail_ff [eisr_pkg::TAIL_DEPTH];
   eisr_pkg::letter_type tail_in [eisr_pkg::TAIL_DEPTH];
   eisr_pkg::count_type  count_ff, count_in;

   // input stage: post-shift snapshot of the lemma tail
   eisr_pkg::letter_type s1_tail_ff [eisr_pkg::TAIL_DEPTH];
   eisr_pkg::count_type  s1_count_ff;
   eisr_pkg::action_type s1_action_ff;
   logic                 s1_valid_ff, s1_valid_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [eisr_pkg::STRIP_W-1:0]  strip_ff, strip_in;
   logic                          dbl_ff, dbl_in;
   eisr_pkg::letter_type          dletter_ff;
   eisr_pkg::suffix_type          code_ff, code_in;
   logic                          noform_ff, noform_in;

   logic req_fire, out_free, action_ok;
   eisr_pkg::count_type count_inc;

   function automatic logic vowel_letter(eisr_pkg::letter_type c);
      return c == "a" || c == "e" || c == "i" || c == "o" || c == "u";
   endfunction

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      case (req_chan.action)
         eisr_pkg::ACT_PLURAL, eisr_pkg::ACT_PAST, eisr_pkg::ACT_THIRD,
         eisr_pkg::ACT_GERUND, eisr_pkg::ACT_COMPARATIVE,
         eisr_pkg::ACT_SUPERLATIVE: action_ok = 1'b1;
         default:                   action_ok = 1'b0;
      endcase
   end

   assign count_inc = (count_ff < eisr_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      tail_in[0] = req_chan.letter;
      for (int i = 1; i < eisr_pkg::TAIL_DEPTH; i++) begin
         tail_in[i] = tail_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < eisr_pkg::TAIL_DEPTH; i++) begin
            tail_ff[i] <= '0;
         end
         count_ff <= '0;
      end else if (req_fire) begin
         // lemma ends: back to the reset state
         for (int i = 0; i < eisr_pkg::TAIL_DEPTH; i++) begin
            tail_ff[i] <= req_chan.last ? '0 : tail_in[i];
         end
         count_ff <= req_chan.last ? '0 : count_in;
      end
   end

   assign count_in = count_inc;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = req_chan.last && action_ok;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < eisr_pkg::TAIL_DEPTH; i++) begin
            s1_tail_ff[i] <= tail_in[i];
         end
         s1_count_ff  <= count_inc;
         s1_action_ff <= eisr_pkg::action_type'(req_chan.action);
      end
   end

   // ---- rule logic on the input stage ----
   eisr_pkg::letter_type t0, t1, t2, t3;
   logic ge1, ge2, ge3, ge4;
   logic end_s, end_sh, end_ch, end_x, end_z, end_o, end_e, end_ie, end_ee;
   logic cvc, cons_y, more_most;

   assign t0 = s1_tail_ff[0];
   assign t1 = s1_tail_ff[1];
   assign t2 = s1_tail_ff[2];
   assign t3 = s1_tail_ff[3];
   assign ge1 = s1_count_ff >= eisr_pkg::count_type'(1);
   assign ge2 = s1_count_ff >= eisr_pkg::count_type'(2);
   assign ge3 = s1_count_ff >= eisr_pkg::count_type'(3);
   assign ge4 = s1_count_ff >= eisr_pkg::count_type'(4);

   assign end_s  = ge1 && t0 == "s";
   assign end_x  = ge1 && t0 == "x";
   assign end_z  = ge1 && t0 == "z";
   assign end_o  = ge1 && t0 == "o";
   assign end_e  = ge1 && t0 == "e";
   assign end_sh = ge2 && t1 == "s" && t0 == "h";
   assign end_ch = ge2 && t1 == "c" && t0 == "h";
   assign end_ie = ge2 && t1 == "i" && t0 == "e";
   assign end_ee = ge2 && t1 == "e" && t0 == "e";

   assign cvc = (s1_count_ff == eisr_pkg::count_type'(3) ||
                 s1_count_ff == eisr_pkg::count_type'(4)) &&
                !(t1 == "e" && (t0 == "n" || t0 == "r" || t0 == "l")) &&
                !vowel_letter(t2) && vowel_letter(t1) && !vowel_letter(t0) &&
                t0 != "w" && t0 != "x" && t0 != "y";

   assign cons_y = ge2 && t0 == "y" && !vowel_letter(t1);

   // suffixes that take more/most
   assign more_most =
      (ge2 && ((t1 == "e" && t0 == "d") || (t1 == "a" && t0 == "l") ||
               (t1 == "i" && t0 == "c"))) ||
      (ge3 && ((t2 == "f" && t1 == "u" && t0 == "l") ||
               (t2 == "o" && t1 == "u" && t0 == "s") ||
               (t2 == "i" && t1 == "v" && t0 == "e") ||
               (t2 == "i" && t1 == "n" && t0 == "g") ||
               (t2 == "i" && t1 == "s" && t0 == "h") ||
               (t2 == "e" && t1 == "n" && t0 == "t") ||
               (t2 == "a" && t1 == "n" && t0 == "t") ||
               (t2 == "a" && t1 == "r" && t0 == "y") ||
               (t2 == "o" && t1 == "r" && t0 == "y"))) ||
      (ge4 && ((t3 == "l" && t2 == "e" && t1 == "s" && t0 == "s") ||
               (t3 == "a" && t2 == "b" && t1 == "l" && t0 == "e") ||
               (t3 == "i" && t2 == "b" && t1 == "l" && t0 == "e")));

   always_comb begin
      strip_in  = '0;
      dbl_in    = 1'b0;
      code_in   = eisr_pkg::SFX_S;
      noform_in = 1'b0;
      case (s1_action_ff)
         eisr_pkg::ACT_PLURAL, eisr_pkg::ACT_THIRD: begin
            if (end_s || end_sh || end_ch || end_x || end_z ||
                (s1_action_ff == eisr_pkg::ACT_THIRD && end_o)) begin
               code_in = eisr_pkg::SFX_ES;
            end else if (cons_y) begin
               strip_in = 2'd1;
               code_in  = eisr_pkg::SFX_IES;
            end
         end
         eisr_pkg::ACT_PAST: begin
            code_in = eisr_pkg::SFX_ED;
            if (cons_y) begin
               strip_in = 2'd1;
               code_in  = eisr_pkg::SFX_IED;
            end else if (end_e) begin
               code_in = eisr_pkg::SFX_D;
            end else if (cvc) begin
               dbl_in = 1'b1;
            end
         end
         eisr_pkg::ACT_GERUND: begin
            code_in = eisr_pkg::SFX_ING;
            if (end_ie) begin
               strip_in = 2'd2;
               code_in  = eisr_pkg::SFX_YING;
            end else if (ge2 && t0 == "e" && !end_ee) begin
               strip_in = 2'd1;
            end else if (cvc) begin
               dbl_in = 1'b1;
            end
         end
         default: begin
            if (more_most) begin
               noform_in = 1'b1;
            end else begin
               code_in = (s1_action_ff == eisr_pkg::ACT_COMPARATIVE) ?
                         eisr_pkg::SFX_ER : eisr_pkg::SFX_EST;
               if (cons_y) begin
                  strip_in = 2'd1;
                  code_in  = (s1_action_ff == eisr_pkg::ACT_COMPARATIVE) ?
                             eisr_pkg::SFX_IER : eisr_pkg::SFX_IEST;
               end else if (end_e) begin
                  code_in = (s1_action_ff == eisr_pkg::ACT_COMPARATIVE) ?
                            eisr_pkg::SFX_R : eisr_pkg::SFX_ST;
               end else if (cvc) begin
                  dbl_in = 1'b1;
               end
            end
         end
      endcase
   end

   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         strip_ff   <= strip_in;
         dbl_ff     <= dbl_in;
         dletter_ff <= t0;
         code_ff    <= code_in;
         noform_ff  <= noform_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.strip_count    = strip_ff;
   assign rsp_chan.double_final   = dbl_ff;
   assign rsp_chan.doubled_letter = dletter_ff;
   assign rsp_chan.suffix_code    = code_ff;
   assign rsp_chan.no_form        = noform_ff;

endmodule
